@@ rtl/bdgd_pkg.sv @@
// shared types and constants of the button debounce and gesture detector
// no dependencies; imported by the top level and its checker
package bdgd_pkg;

	// gesture codes on the result channel
	typedef enum logic [1:0] {
		G_NONE   = 2'd0,
		G_SINGLE = 2'd1,
		G_TRIPLE = 2'd2,
		G_LONG   = 2'd3
	} gesture_t;

	// register map, word index = paddr[3:2]
	localparam int unsigned ADDR_W = 4;
	typedef enum logic [1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_WINDOW   = 2'd1,
		REG_LONG     = 2'd2,
		REG_NONE     = 2'd3
	} reg_idx_t;

	localparam logic [15:0] DEBOUNCE_RST = 16'd40;
	localparam logic [15:0] WINDOW_RST   = 16'd400;
	localparam logic [15:0] LONG_RST     = 16'd1000;

	// press number that completes a triple click
	localparam logic [1:0] TRIPLE_COUNT = 2'd3;

endpackage

@@ rtl/button_debounce_gesture_detector.sv @@
// button debounce with single click, triple click and long press detection
// depends on bdgd_pkg; configuration through a small apb-style register port
//
// Each input transaction carries one raw button sample and the millisecond time; every
// one gives exactly one gesture transaction (none, single press, triple click, long
// press). A sample is taken into an input register, and from there short compare and
// subtract logic updates the debounce and gesture state and loads the result register,
// so one sample is accepted every clock cycle while the output is not stalled. A stalled
// result holds the output register while one more sample waits in the input register.
// Registers: 0x0 debounce_ms, 0x4 multi_click_window_ms, 0x8 long_press_ms, 16 bits
// each; write them only while no transaction is in flight.
module button_debounce_gesture_detector (
	input  logic                        clk,
	input  logic                        arst_n,
	// sample channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        raw_pressed,
	input  logic [31:0]                 now_ms,
	// gesture channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  gesture,
	// register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bdgd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import bdgd_pkg::*;

	// configuration registers
	logic [15:0] debounce_q;
	logic [15:0] window_q;
	logic [15:0] long_q;
	reg_idx_t    reg_idx;
	logic        cfg_wr;

	// input stage
	logic        valid_s1;
	logic        raw_s1;
	logic [31:0] now_s1;

	// result register
	logic        out_valid_q;
	gesture_t    gesture_q;

	// debounce and gesture state
	logic        cand_q;
	logic [31:0] cand_since_q;
	logic        deb_q;
	logic        act_q;
	logic [31:0] first_q;
	logic [31:0] pdown_q;
	logic [1:0]  cnt_q;
	logic        swallow_q;

	// next state
	logic        cand_n;
	logic [31:0] cand_since_n;
	logic        deb_n;
	logic        act_n;
	logic [31:0] first_n;
	logic [31:0] pdown_n;
	logic [1:0]  cnt_n;
	logic        swallow_n;
	gesture_t    g_n;

	logic        out_free;
	logic        s1_fire;
	logic        in_fire;

	// elapsed times, wrapping 32-bit differences
	logic [31:0] stable_el;
	logic [31:0] win_el;
	logic [31:0] hold_el;
	logic        stable_ok;
	logic        win_over;
	logic        long_ok;

	// ---------------------------------------------------------------- register port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			window_q   <= WINDOW_RST;
			long_q     <= LONG_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_DEBOUNCE: debounce_q <= pwdata[15:0];
				REG_WINDOW:   window_q   <= pwdata[15:0];
				REG_LONG:     long_q     <= pwdata[15:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DEBOUNCE: prdata = {16'd0, debounce_q};
			REG_WINDOW:   prdata = {16'd0, window_q};
			REG_LONG:     prdata = {16'd0, long_q};
			default:      prdata = 32'd0;
		endcase
	end

	// ---------------------------------------------------------------- flow control
	// the result register frees when empty or taken this cycle
	assign out_free = !out_valid_q || out_ready;
	assign s1_fire  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			raw_s1 <= raw_pressed;
			now_s1 <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			gesture_q <= g_n;
		end
	end

	assign out_valid = out_valid_q;
	assign gesture   = gesture_q;

	// ---------------------------------------------------------------- gesture logic
	assign stable_el = now_s1 - cand_since_q;
	assign win_el    = now_s1 - first_q;
	assign hold_el   = now_s1 - pdown_q;
	assign stable_ok = stable_el >= {16'd0, debounce_q};
	assign win_over  = win_el >= {16'd0, window_q};
	assign long_ok   = hold_el >= {16'd0, long_q};

	always_comb begin
		cand_n       = cand_q;
		cand_since_n = cand_since_q;
		deb_n        = deb_q;
		act_n        = act_q;
		first_n      = first_q;
		pdown_n      = pdown_q;
		cnt_n        = cnt_q;
		swallow_n    = swallow_q;
		g_n          = G_NONE;

		if (raw_s1 != cand_q || !(cand_q != deb_q && stable_ok)) begin
			// raw change restarts the stability timer, no edge in that sample
			if (raw_s1 != cand_q) begin
				cand_n       = raw_s1;
				cand_since_n = now_s1;
			end
			// window expiry while released closes the sequence
			if (act_q && !deb_q && win_over) begin
				g_n     = (cnt_q != 2'd0) ? G_SINGLE : G_NONE;
				act_n   = 1'b0;
				first_n = 32'd0;
				pdown_n = 32'd0;
				cnt_n   = 2'd0;
			end
		end else if (cand_q) begin
			// debounced press
			deb_n = 1'b1;
			if (act_q && !win_over && (cnt_q + 2'd1) == TRIPLE_COUNT) begin
				// third press inside the window: report now, swallow its release
				g_n       = G_TRIPLE;
				act_n     = 1'b0;
				first_n   = 32'd0;
				pdown_n   = 32'd0;
				cnt_n     = 2'd0;
				swallow_n = 1'b1;
			end else begin
				// no open sequence or window over: start a fresh one here
				if (!act_q || win_over) begin
					act_n   = 1'b1;
					first_n = now_s1;
					cnt_n   = 2'd0;
				end
				pdown_n = now_s1;
			end
		end else begin
			// debounced release
			deb_n = 1'b0;
			if (swallow_q) begin
				swallow_n = 1'b0;
			end else if (act_q) begin
				if (long_ok) begin
					g_n     = G_LONG;
					act_n   = 1'b0;
					first_n = 32'd0;
					pdown_n = 32'd0;
					cnt_n   = 2'd0;
				end else if (win_over) begin
					// click completes after the window: single press
					g_n     = G_SINGLE;
					act_n   = 1'b0;
					first_n = 32'd0;
					pdown_n = 32'd0;
					cnt_n   = 2'd0;
				end else if (cnt_q != TRIPLE_COUNT) begin
					// count saturates
					cnt_n = cnt_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q       <= 1'b0;
			cand_since_q <= 32'd0;
			deb_q        <= 1'b0;
			act_q        <= 1'b0;
			first_q      <= 32'd0;
			pdown_q      <= 32'd0;
			cnt_q        <= 2'd0;
			swallow_q    <= 1'b0;
		end else if (s1_fire) begin
			cand_q       <= cand_n;
			cand_since_q <= cand_since_n;
			deb_q        <= deb_n;
			act_q        <= act_n;
			first_q      <= first_n;
			pdown_q      <= pdown_n;
			cnt_q        <= cnt_n;
			swallow_q    <= swallow_n;
		end
	end

endmodule

@@ rtl/bdgd_checker.sv @@
// port-level checks for the button debounce and gesture detector
// depends on bdgd_pkg; bound to the top level at the end of this file
module bdgd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        raw_pressed,
	input logic [31:0]                 now_ms,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [1:0]                  gesture,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [bdgd_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                 pwdata,
	input logic [31:0]                 prdata,
	input logic                        pready
);
	import bdgd_pkg::*;

	// a stalled gesture holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gesture))
		else $error("stalled gesture transaction changed");

	// with nothing waiting at the output the block takes a sample
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("sample refused with empty output");

	// every accepted sample shows a result once it has passed the input and result registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("no gesture transaction after accepted sample");

	// a written debounce time reads back
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[3:2] == REG_DEBOUNCE)
		##1 (psel && !pwrite && paddr[3:2] == REG_DEBOUNCE)
		|-> prdata[15:0] == $past(pwdata[15:0]))
		else $error("debounce register readback mismatch");

endmodule

bind button_debounce_gesture_detector bdgd_checker u_bdgd_checker (.*);
